/* design/polygon_point_inclusion_assert.svh */
// Assertion macros shared by the polygon point inclusion RTL.
`ifndef POLYGON_POINT_INCLUSION_ASSERT_SVH
`define POLYGON_POINT_INCLUSION_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define PPI_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ppi same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define PPI_CHECK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ppi next-cycle check failed");

`endif

/* design/ppi_pkg.sv */
// Shared types, constants and helpers for the polygon point inclusion block.
`default_nettype none

package ppi_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 16;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int EXT_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * EXT_BITS;
    localparam int AREA_BITS    = 42;
    localparam int SUM_BITS     = AREA_BITS + 1;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic {
        KIND_SUMMARY = 1'b0,
        KIND_QUERY   = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_POLY  = 2'd1,
        STAT_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_ADRAIN,
        ST_WALK,
        ST_QDRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] max_y;
    } box_t;

    typedef struct packed {
        action_t                      action;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic                         last_vertex;
    } in_t;

    typedef struct packed {
        kind_t                        kind;
        logic                         inside_res;
        logic [AREA_BITS-1:0]         twice_area;
        logic signed [COORD_BITS-1:0] box_min_x;
        logic signed [COORD_BITS-1:0] box_max_x;
        logic signed [COORD_BITS-1:0] box_min_y;
        logic signed [COORD_BITS-1:0] box_max_y;
        status_t                      status;
    } out_t;

    // Control and status between the sequencer and the shoelace unit.
    typedef struct packed {
        logic clr;
        logic term_vld;
    } area_ctl_t;

    typedef struct packed {
        logic busy;
    } area_sts_t;

    // Control and status between the sequencer and the edge test pipeline.
    typedef struct packed {
        logic start;
        logic issue;
    } edge_ctl_t;

    typedef struct packed {
        logic busy;
        logic odd;
    } edge_sts_t;

    // Sign-extend one coordinate by a bit so sums and differences cannot wrap.
    function automatic logic signed [EXT_BITS-1:0] sext1(input logic signed [COORD_BITS-1:0] c);
        return {c[COORD_BITS-1], c};
    endfunction

endpackage

`default_nettype wire

/* design/ppi_vram.sv */
// Vertex store: one write port, one registered read port.
`default_nettype none

module ppi_vram (
    input  wire                       aclk,
    input  wire                       we,
    input  wire [ppi_pkg::ADDR_BITS-1:0] waddr,
    input  ppi_pkg::vertex_t          wdata,
    input  wire                       re,
    input  wire [ppi_pkg::ADDR_BITS-1:0] raddr,
    output ppi_pkg::vertex_t          rdata
);
    import ppi_pkg::*;

    vertex_t mem [MAX_VERTICES];
    vertex_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/ppi_area.sv */
// Shoelace accumulator: one product per term, saturating running sum.
`default_nettype none

module ppi_area (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  ppi_pkg::area_ctl_t         ctl,
    input  ppi_pkg::vertex_t           va,
    input  ppi_pkg::vertex_t           vb,
    output ppi_pkg::area_sts_t         sts,
    output logic [ppi_pkg::AREA_BITS-1:0] twice_area
);
    import ppi_pkg::*;

    logic signed [EXT_BITS-1:0]  xsum;
    logic signed [EXT_BITS-1:0]  ydiff;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        prod_vld_reg;
    logic [SUM_BITS-1:0]         sum_reg;
    logic [SUM_BITS-1:0]         sum_next;
    logic [SUM_BITS:0]           sum_wide;
    logic [SUM_BITS-1:0]         mag;

    assign xsum  = sext1(va.x) + sext1(vb.x);
    assign ydiff = sext1(va.y) - sext1(vb.y);

    always_ff @(posedge aclk) begin
        prod_reg <= xsum * ydiff;
    end

    // Add one guard bit, then clamp to the signed sum range.
    assign sum_wide = {sum_reg[SUM_BITS-1], sum_reg}
                    + {{(SUM_BITS + 1 - PROD_BITS){prod_reg[PROD_BITS-1]}}, prod_reg};

    always_comb begin
        sum_next = sum_reg;
        if (ctl.clr) begin
            sum_next = '0;
        end else if (prod_vld_reg) begin
            if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
                sum_next = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                              : {1'b0, {(SUM_BITS-1){1'b1}}};
            end else begin
                sum_next = sum_wide[SUM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            sum_reg      <= '0;
        end else begin
            prod_vld_reg <= ctl.term_vld;
            sum_reg      <= sum_next;
        end
    end

    // Magnitude; the most negative sum clamps to the top of the area range.
    assign mag        = sum_reg[SUM_BITS-1] ? (~sum_reg + SUM_BITS'(1)) : sum_reg;
    assign twice_area = mag[SUM_BITS-1] ? '1 : mag[AREA_BITS-1:0];
    assign sts.busy   = prod_vld_reg;

endmodule

`default_nettype wire

/* design/ppi_edge.sv */
// Edge crossing pipeline: one edge per cycle, even-odd flag at the end.
`default_nettype none

module ppi_edge (
    input  wire                aclk,
    input  wire                aresetn,
    input  ppi_pkg::edge_ctl_t ctl,
    input  ppi_pkg::vertex_t   seed,
    input  ppi_pkg::vertex_t   point,
    input  ppi_pkg::vertex_t   rd_data,
    output ppi_pkg::edge_sts_t sts
);
    import ppi_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic inside_reg;
    vertex_t b_reg;

    logic ua, ub;
    logic cross1_reg, dpos1_reg;
    logic signed [EXT_BITS-1:0] d1_reg, dxp1_reg, dxb1_reg, dyp1_reg;
    logic cross2_reg, dpos2_reg;
    logic signed [PROD_BITS-1:0] lhs2_reg, rhs2_reg;
    logic hit;

    // rd_data is vertex i, b_reg is vertex j (the one read before it).
    assign ua = $signed(rd_data.y) > $signed(point.y);
    assign ub = $signed(b_reg.y) > $signed(point.y);

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            b_reg <= seed;
        end else if (v1_reg) begin
            b_reg <= rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        cross1_reg <= ua ^ ub;
        dpos1_reg  <= ub;
        d1_reg     <= sext1(b_reg.y) - sext1(rd_data.y);
        dxp1_reg   <= sext1(point.x) - sext1(rd_data.x);
        dxb1_reg   <= sext1(b_reg.x) - sext1(rd_data.x);
        dyp1_reg   <= sext1(point.y) - sext1(rd_data.y);
        cross2_reg <= cross1_reg;
        dpos2_reg  <= dpos1_reg;
        lhs2_reg   <= dxp1_reg * d1_reg;
        rhs2_reg   <= dxb1_reg * dyp1_reg;
    end

    assign hit = cross2_reg && (dpos2_reg ? (lhs2_reg < rhs2_reg) : (lhs2_reg > rhs2_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            inside_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (ctl.start) begin
                inside_reg <= 1'b0;
            end else if (v3_reg && hit) begin
                inside_reg <= ~inside_reg;
            end
        end
    end

    assign sts.busy = v1_reg | v2_reg | v3_reg;
    assign sts.odd  = inside_reg;

endmodule

`default_nettype wire

/* design/polygon_point_inclusion.sv */
// Top level of the even-odd point-in-polygon block: sequencer, vertex store and units.
`default_nettype none

// Load beats (action = load) write one vertex each into a 256-entry vertex
// memory and update a running bounding box and a saturating shoelace sum.
// A load beat without last_vertex gives no result. The load beat marked
// last adds the closing term (last vertex back to the first) and returns a
// summary beat with twice the absolute area, the box and status (2 if
// vertices beyond 256 were dropped).
// A load arriving after a finished polygon discards it and starts a new one.
// Query beats return one answer each. With no finished polygon the answer
// has status 1 and zero fields; a point outside the box is answered
// "outside" without a walk. A point inside the box walks every stored edge
// through the single read port of the vertex memory, one edge per cycle,
// followed by a three-stage crossing test.
// The crossing abscissa is compared exactly by cross-multiplication, so no
// rounding ever occurs. A finished result waits in the output register while
// the next beat is taken; the block stalls only if a second result is ready
// before the first has left.
module polygon_point_inclusion (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  ppi_pkg::in_t   s_data,
    output logic           m_valid,
    input  wire            m_ready,
    output ppi_pkg::out_t  m_data
);
    import ppi_pkg::*;

    `include "polygon_point_inclusion_assert.svh"

    // Sequencer state and polygon state.
    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    vertex_t             first_reg, prev_reg, pt_reg;
    box_t                box_reg, box_next;
    logic                ready_reg, ready_next;
    logic                ovf_reg, ovf_next;

    // Pending result description.
    kind_t   res_kind_reg, res_kind_next;
    logic    res_inside_reg, res_inside_next;
    logic    res_fill_reg, res_fill_next;
    status_t res_status_reg, res_status_next;

    logic m_valid_reg;
    out_t m_data_reg;

    // Beat decode.
    logic                acc, is_load, is_query;
    vertex_t             pin;
    logic [CNT_BITS-1:0] cnt_eff;
    logic                full, store, in_box, slot_free, walk_last;
    status_t             ovf_status;

    // Unit hookup.
    area_ctl_t           area_ctl;
    area_sts_t           area_sts;
    vertex_t             area_b;
    logic [AREA_BITS-1:0] twice_area;
    edge_ctl_t           edge_ctl;
    edge_sts_t           edge_sts;
    vertex_t             rd_data;
    logic                mem_we;

    assign acc      = s_valid && s_ready;
    assign is_load  = acc && (s_data.action == ACT_LOAD);
    assign is_query = acc && (s_data.action == ACT_QUERY);
    assign pin      = '{x: s_data.coord_x, y: s_data.coord_y};

    // A finished polygon is dropped by the next load: count restarts at zero.
    assign cnt_eff   = ready_reg ? '0 : count_reg;
    assign full      = cnt_eff >= CNT_BITS'(MAX_VERTICES);
    assign store     = is_load && !full;
    assign mem_we    = store;

    assign in_box = ($signed(pin.x) >= $signed(box_reg.min_x))
                 && ($signed(pin.x) <= $signed(box_reg.max_x))
                 && ($signed(pin.y) >= $signed(box_reg.min_y))
                 && ($signed(pin.y) <= $signed(box_reg.max_y));

    assign slot_free  = !m_valid_reg || m_ready;
    assign walk_last  = idx_reg == (count_reg - CNT_BITS'(1));
    assign ovf_status = ovf_reg ? STAT_OVERFLOW : STAT_OK;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (is_load && s_data.last_vertex) begin
                    state_next = ST_CLOSE;
                end else if (is_query) begin
                    state_next = (ready_reg && in_box) ? ST_WALK : ST_EMIT;
                end
            end
            ST_CLOSE:  state_next = ST_ADRAIN;
            ST_ADRAIN: if (!area_sts.busy) state_next = ST_EMIT;
            ST_WALK:   if (walk_last) state_next = ST_QDRAIN;
            ST_QDRAIN: if (!edge_sts.busy) state_next = ST_EMIT;
            ST_EMIT:   if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready           = 1'b0;
        area_ctl.clr      = 1'b0;
        area_ctl.term_vld = 1'b0;
        area_b            = pin;
        edge_ctl.start    = 1'b0;
        edge_ctl.issue    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready           = 1'b1;
                area_ctl.clr      = is_load && ready_reg;
                area_ctl.term_vld = store && (cnt_eff != '0);
                edge_ctl.start    = is_query;
            end
            ST_CLOSE: begin
                // Close the ring: last vertex back to the first.
                area_ctl.term_vld = 1'b1;
                area_b            = first_reg;
            end
            ST_WALK: begin
                edge_ctl.issue = 1'b1;
            end
            ST_ADRAIN, ST_QDRAIN, ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // Polygon state and result description updates.
    always_comb begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        box_next        = box_reg;
        ready_next      = ready_reg;
        ovf_next        = ovf_reg;
        res_kind_next   = res_kind_reg;
        res_inside_next = res_inside_reg;
        res_fill_next   = res_fill_reg;
        res_status_next = res_status_reg;

        if (is_load) begin
            ready_next = 1'b0;
            ovf_next   = (ready_reg ? 1'b0 : ovf_reg) | full;
            count_next = store ? (cnt_eff + CNT_BITS'(1)) : cnt_eff;
            if (store) begin
                if (cnt_eff == '0) begin
                    box_next = '{min_x: pin.x, max_x: pin.x, min_y: pin.y, max_y: pin.y};
                end else begin
                    if ($signed(pin.x) < $signed(box_reg.min_x)) box_next.min_x = pin.x;
                    if ($signed(pin.x) > $signed(box_reg.max_x)) box_next.max_x = pin.x;
                    if ($signed(pin.y) < $signed(box_reg.min_y)) box_next.min_y = pin.y;
                    if ($signed(pin.y) > $signed(box_reg.max_y)) box_next.max_y = pin.y;
                end
            end
        end

        if (is_query) begin
            idx_next        = '0;
            res_kind_next   = KIND_QUERY;
            res_inside_next = 1'b0;
            res_fill_next   = ready_reg;
            res_status_next = ready_reg ? ovf_status : STAT_NO_POLY;
        end

        if (state_reg == ST_WALK) begin
            idx_next = idx_reg + CNT_BITS'(1);
        end

        if ((state_reg == ST_ADRAIN) && !area_sts.busy) begin
            ready_next      = 1'b1;
            res_kind_next   = KIND_SUMMARY;
            res_inside_next = 1'b0;
            res_fill_next   = 1'b1;
            res_status_next = ovf_status;
        end

        if ((state_reg == ST_QDRAIN) && !edge_sts.busy) begin
            res_inside_next = edge_sts.odd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            box_reg        <= '0;
            ready_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            first_reg      <= '0;
            prev_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            box_reg   <= box_next;
            ready_reg <= ready_next;
            ovf_reg   <= ovf_next;
            if (store) begin
                prev_reg <= pin;
                if (cnt_eff == '0) begin
                    first_reg <= pin;
                end
            end
            // Hold the result until taken; load a new one only into a free slot.
            if ((state_reg == ST_EMIT) && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        res_kind_reg   <= res_kind_next;
        res_inside_reg <= res_inside_next;
        res_fill_reg   <= res_fill_next;
        res_status_reg <= res_status_next;
        if (acc) begin
            pt_reg <= pin;
        end
        if ((state_reg == ST_EMIT) && slot_free) begin
            m_data_reg.kind       <= res_kind_reg;
            m_data_reg.inside_res <= res_inside_reg;
            m_data_reg.twice_area <= res_fill_reg ? twice_area : '0;
            m_data_reg.box_min_x  <= res_fill_reg ? box_reg.min_x : '0;
            m_data_reg.box_max_x  <= res_fill_reg ? box_reg.max_x : '0;
            m_data_reg.box_min_y  <= res_fill_reg ? box_reg.min_y : '0;
            m_data_reg.box_max_y  <= res_fill_reg ? box_reg.max_y : '0;
            m_data_reg.status     <= res_status_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ppi_vram u_vram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (cnt_eff[ADDR_BITS-1:0]),
        .wdata (pin),
        .re    (edge_ctl.issue),
        .raddr (idx_reg[ADDR_BITS-1:0]),
        .rdata (rd_data)
    );

    ppi_area u_area (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (area_ctl),
        .va         (prev_reg),
        .vb         (area_b),
        .sts        (area_sts),
        .twice_area (twice_area)
    );

    // The walk starts with vertex j = last stored vertex, which is prev_reg.
    ppi_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (edge_ctl),
        .seed    (prev_reg),
        .point   (pt_reg),
        .rd_data (rd_data),
        .sts     (edge_sts)
    );

    `PPI_CHECK_IMP(a_ready_has_vertices, ready_reg, count_reg != '0)
    `PPI_CHECK_IMP(a_count_bounded, 1'b1, count_reg <= CNT_BITS'(MAX_VERTICES))
    `PPI_CHECK_IMP(a_walk_in_range, state_reg == ST_WALK, idx_reg < count_reg)
    `PPI_CHECK_IMP(a_walk_area_quiet, state_reg == ST_WALK, !area_sts.busy)
    `PPI_CHECK_NXT(a_last_closes, is_load && s_data.last_vertex, state_reg == ST_CLOSE)

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the polygon point inclusion block: scoreboard, drivers, top.
import ppi_pkg::*;

class poly_scoreboard;
    localparam longint SUM_HI   = (longint'(1) <<< AREA_BITS) - 1;
    localparam longint SUM_LO   = -(longint'(1) <<< AREA_BITS);
    localparam longint AREA_CAP = (longint'(1) <<< AREA_BITS) - 1;

    vertex_t corners[MAX_VERTICES];
    int      corner_count = 0;
    vertex_t first_corner = '0;
    vertex_t last_corner  = '0;
    box_t    extent       = '0;
    longint  shoelace     = 0;
    bit      closed       = 0;
    bit      dropped      = 0;

    out_t    awaited[$];
    int      failures = 0;
    int      matched  = 0;
    int      n_summary = 0, n_overflow = 0, n_answers = 0, n_in = 0, n_no_poly = 0;

    function void add_term(vertex_t a, vertex_t b);
        longint s;
        s = shoelace + (longint'(a.x) + longint'(b.x)) * (longint'(a.y) - longint'(b.y));
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        shoelace = s;
    endfunction

    // Ray from p toward +x against edge a-b, compared without division.
    function bit edge_crossed(vertex_t p, vertex_t a, vertex_t b);
        longint d, lhs, rhs;
        if ((a.y > p.y) == (b.y > p.y)) return 1'b0;
        d   = longint'(b.y) - longint'(a.y);
        lhs = (longint'(p.x) - longint'(a.x)) * d;
        rhs = (longint'(b.x) - longint'(a.x)) * (longint'(p.y) - longint'(a.y));
        return d > 0 ? lhs < rhs : lhs > rhs;
    endfunction

    function out_t make_result(kind_t k, bit in_flag, status_t st, bit fill);
        out_t   r;
        longint mag;
        r            = '0;
        r.kind       = k;
        r.inside_res = in_flag;
        r.status     = st;
        if (fill) begin
            mag = shoelace < 0 ? -shoelace : shoelace;
            if (mag > AREA_CAP) mag = AREA_CAP;
            r.twice_area = mag[AREA_BITS-1:0];
            r.box_min_x  = extent.min_x;
            r.box_max_x  = extent.max_x;
            r.box_min_y  = extent.min_y;
            r.box_max_y  = extent.max_y;
        end
        return r;
    endfunction

    function string describe(out_t r);
        return $sformatf("kind=%0d in=%0d area=%0d x[%0d..%0d] y[%0d..%0d] status=%0d",
                         r.kind, r.inside_res, r.twice_area, r.box_min_x, r.box_max_x,
                         r.box_min_y, r.box_max_y, r.status);
    endfunction

    function void note_input(in_t beat);
        vertex_t p;
        bit      odd;
        int      j;
        p.x = beat.coord_x;
        p.y = beat.coord_y;
        if (beat.action == ACT_LOAD) begin
            if (closed) begin
                closed       = 0;
                corner_count = 0;
                shoelace     = 0;
                dropped      = 0;
                extent       = '0;
            end
            if (corner_count >= MAX_VERTICES) begin
                dropped = 1;
            end else begin
                corners[corner_count] = p;
                if (corner_count == 0) begin
                    first_corner = p;
                    extent.min_x = p.x;
                    extent.max_x = p.x;
                    extent.min_y = p.y;
                    extent.max_y = p.y;
                end else begin
                    add_term(last_corner, p);
                    if (p.x < extent.min_x) extent.min_x = p.x;
                    if (p.x > extent.max_x) extent.max_x = p.x;
                    if (p.y < extent.min_y) extent.min_y = p.y;
                    if (p.y > extent.max_y) extent.max_y = p.y;
                end
                last_corner = p;
                corner_count++;
            end
            if (beat.last_vertex) begin
                add_term(last_corner, first_corner);
                closed = 1;
                n_summary++;
                if (dropped) n_overflow++;
                awaited = {awaited, make_result(KIND_SUMMARY, 1'b0,
                                                dropped ? STAT_OVERFLOW : STAT_OK, 1'b1)};
            end
        end else if (!closed) begin
            n_no_poly++;
            awaited = {awaited, make_result(KIND_QUERY, 1'b0, STAT_NO_POLY, 1'b0)};
        end else begin
            odd = 0;
            if (!(p.x < extent.min_x || p.x > extent.max_x ||
                  p.y < extent.min_y || p.y > extent.max_y)) begin
                j = corner_count - 1;
                for (int i = 0; i < corner_count; i++) begin
                    if (edge_crossed(p, corners[i], corners[j])) odd = !odd;
                    j = i;
                end
            end
            n_answers++;
            if (odd) n_in++;
            awaited = {awaited, make_result(KIND_QUERY, odd,
                                            dropped ? STAT_OVERFLOW : STAT_OK, 1'b1)};
        end
    endfunction

    function void check_result(out_t got);
        out_t want;
        if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected result beat: %s", describe(got));
            return;
        end
        want = awaited.pop_front();
        if (got.kind !== want.kind || got.inside_res !== want.inside_res ||
            got.twice_area !== want.twice_area ||
            got.box_min_x !== want.box_min_x || got.box_max_x !== want.box_max_x ||
            got.box_min_y !== want.box_min_y || got.box_max_y !== want.box_max_y ||
            got.status !== want.status) begin
            failures++;
            if (failures <= 10) begin
                $display("result mismatch");
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        end else begin
            matched++;
        end
    endfunction
endclass

module testbench;
    import ppi_pkg::*;

    // Watchdog bound for an honest run of under a thousand beats, with sender gaps
    // and receiver stalls; it is set far above what such a run needs.
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 410;

    typedef enum int {
        SHAPE_TIGHT,
        SHAPE_WIDE,
        SHAPE_ANY
    } shape_style_t;

    logic  aclk;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    int    send_idle_pct = 30;
    int    recv_idle_pct = 78;
    int    beats_sent    = 0;

    // Generator-side copy of the polygon being loaded, used only to aim queries.
    vertex_t shape[$];
    box_t    shape_box  = '0;
    bit      shape_done = 1'b0;

    poly_scoreboard sb = new();

    polygon_point_inclusion dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stall the result channel at random; the rate changes per phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sample both handshakes with pre-edge values: note accepted inputs, check results.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    function automatic logic signed [COORD_BITS-1:0] clip(int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] any_coord();
        logic [31:0] r;
        r = $urandom;
        return r[COORD_BITS-1:0];
    endfunction

    // Present one beat, idling first at the current sender rate; hold valid and
    // payload until accepted. Valid is dropped only when an idle cycle follows.
    task automatic send_beat(input in_t beat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (s_ready !== 1'b1);
        beats_sent++;
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.awaited.size() != 0) @(posedge aclk);
    endtask

    task automatic load_vertex(input logic signed [COORD_BITS-1:0] x, y, input bit last);
        in_t     beat;
        vertex_t v;
        beat.action      = ACT_LOAD;
        beat.coord_x     = x;
        beat.coord_y     = y;
        beat.last_vertex = last;
        v.x = x;
        v.y = y;
        // A load after a finished polygon starts a new one; mirror that here.
        if (shape_done) begin
            shape.delete();
            shape_done = 1'b0;
        end
        if (shape.size() == 0) begin
            shape_box.min_x = x;
            shape_box.max_x = x;
            shape_box.min_y = y;
            shape_box.max_y = y;
        end else if (shape.size() < MAX_VERTICES) begin
            if (x < shape_box.min_x) shape_box.min_x = x;
            if (x > shape_box.max_x) shape_box.max_x = x;
            if (y < shape_box.min_y) shape_box.min_y = y;
            if (y > shape_box.max_y) shape_box.max_y = y;
        end
        if (shape.size() < MAX_VERTICES) shape = {shape, v};
        if (last) shape_done = 1'b1;
        send_beat(beat);
    endtask

    task automatic send_query(input logic signed [COORD_BITS-1:0] x, y, input bit last);
        in_t beat;
        beat.action      = ACT_QUERY;
        beat.coord_x     = x;
        beat.coord_y     = y;
        beat.last_vertex = last;
        send_beat(beat);
    endtask

    // Aim a query at the current shape: inside its box, on a vertex level, on a
    // vertex, on the box border, just outside, or anywhere.
    task automatic query_near_shape();
        int      sel, x, y, lo_x, hi_x, lo_y, hi_y;
        vertex_t v;
        if (shape.size() == 0) begin
            send_query(any_coord(), any_coord(), $urandom_range(1));
            return;
        end
        lo_x = shape_box.min_x;
        hi_x = shape_box.max_x;
        lo_y = shape_box.min_y;
        hi_y = shape_box.max_y;
        v    = shape[$urandom_range(shape.size() - 1)];
        x    = lo_x + int'($urandom_range(hi_x - lo_x));
        y    = lo_y + int'($urandom_range(hi_y - lo_y));
        sel  = $urandom_range(99);
        if (sel < 20) begin
            y = v.y;
        end else if (sel < 30) begin
            x = v.x;
            y = v.y;
        end else if (sel < 40) begin
            x = $urandom_range(1) ? hi_x + int'($urandom_range(1, 50))
                                  : lo_x - int'($urandom_range(1, 50));
        end else if (sel < 48) begin
            x = int'(any_coord());
            y = int'(any_coord());
        end else if (sel < 60) begin
            x = $urandom_range(1) ? lo_x : hi_x;
        end
        // The remaining share keeps the point drawn inside the box.
        send_query(clip(x), clip(y), $urandom_range(1));
    endtask

    // Load one polygon of n vertices; with breaks, drop stray queries into the load.
    task automatic build_polygon(input int n, input shape_style_t style, input bit with_breaks);
        int cx, cy, span, x, y;
        cx   = int'($urandom_range(65535)) - 32768;
        cy   = int'($urandom_range(65535)) - 32768;
        span = style == SHAPE_TIGHT ? int'($urandom_range(1, 40))
                                    : int'($urandom_range(500, 4000));
        for (int i = 0; i < n; i++) begin
            if (with_breaks && i > 0 && $urandom_range(99) < 6)
                send_query(any_coord(), any_coord(), $urandom_range(1));
            if (style == SHAPE_ANY) begin
                x = int'(any_coord());
                y = int'(any_coord());
            end else begin
                x = cx - span + int'($urandom_range(2 * span));
                y = cy - span + int'($urandom_range(2 * span));
            end
            load_vertex(clip(x), clip(y), i == n - 1);
        end
    endtask

    task automatic directed_checks();
        // Query before any polygon exists.
        send_query(-16'sd32768, 16'sd32767, 1'b1);
        send_query(16'sd32767, -16'sd32768, 1'b0);
        // Full-range square: extreme coordinates and the largest area.
        load_vertex(-16'sd32768, -16'sd32768, 1'b0);
        load_vertex(16'sd32767, -16'sd32768, 1'b0);
        load_vertex(16'sd32767, 16'sd32767, 1'b0);
        load_vertex(-16'sd32768, 16'sd32767, 1'b1);
        send_query(16'sd0, 16'sd0, 1'b0);
        send_query(-16'sd32768, -16'sd32768, 1'b1);
        send_query(16'sd32767, 16'sd0, 1'b0);
        send_query(16'sd0, 16'sd32767, 1'b0);
        // Single-vertex and two-vertex polygons: zero area, degenerate edges.
        load_vertex(16'sd100, -16'sd200, 1'b1);
        send_query(16'sd100, -16'sd200, 1'b0);
        load_vertex(16'sd0, 16'sd0, 1'b0);
        load_vertex(16'sd10, 16'sd10, 1'b1);
        send_query(16'sd5, 16'sd5, 1'b0);
        // Triangle with a horizontal base: ray level on the base and on a vertex.
        load_vertex(16'sd0, 16'sd0, 1'b0);
        load_vertex(16'sd20, 16'sd0, 1'b0);
        load_vertex(16'sd10, 16'sd20, 1'b1);
        send_query(16'sd10, 16'sd0, 1'b0);
        send_query(16'sd10, 16'sd10, 1'b0);
        send_query(16'sd10, 16'sd20, 1'b0);
        // Query in the middle of a load answers with no polygon.
        load_vertex(16'sd5, 16'sd5, 1'b0);
        send_query(16'sd5, 16'sd5, 1'b0);
        load_vertex(16'sd50, 16'sd5, 1'b0);
        load_vertex(16'sd50, 16'sd50, 1'b1);
        send_query(16'sd30, 16'sd20, 1'b0);
        // Vertex overflow: extra vertices dropped, status carried into queries.
        build_polygon(MAX_VERTICES + 2, SHAPE_WIDE, 1'b0);
        query_near_shape();
        send_query(shape_box.min_x + 16'sd1, shape[0].y, 1'b0);
        // A new load clears the overflow flag.
        build_polygon(3, SHAPE_TIGHT, 1'b0);
        query_near_shape();
    endtask

    task automatic random_rounds();
        int start, phase, sel, n, k;
        shape_style_t style;
        start = beats_sent;
        phase = 0;
        while (beats_sent - start < RANDOM_ITEMS) begin
            // Advance the idle pattern per third, pausing the sender until all results are in.
            if ((beats_sent - start) * 3 / RANDOM_ITEMS > phase) begin
                phase++;
                drain_results();
                send_idle_pct = phase == 1 ? 78 : 0;
                recv_idle_pct = phase == 1 ? 30 : 0;
            end
            sel = $urandom_range(99);
            if (sel < 5) begin
                k = $urandom_range(1, 3);
                repeat (k) send_query(any_coord(), any_coord(), $urandom_range(1));
            end else begin
                sel = $urandom_range(99);
                if (sel < 8) n = $urandom_range(1, 2);
                else if (sel < 80) n = $urandom_range(3, 10);
                else if (sel < 95) n = $urandom_range(11, 48);
                else if (sel < 99) n = $urandom_range(49, MAX_VERTICES);
                else n = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 6);
                sel = $urandom_range(99);
                style = sel < 50 ? SHAPE_TIGHT : (sel < 80 ? SHAPE_WIDE : SHAPE_ANY);
                build_polygon(n, style, 1'b1);
                k = $urandom_range(1, 6);
                repeat (k) query_near_shape();
            end
        end
    endtask

    // Watchdog: end the run if the block stops answering.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, sb.awaited.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_checks();
        random_rounds();
        drain_results();
        // Hold a while longer to catch any stray result beat.
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Drove %0d beats: %0d polygons closed (%0d overflowed), %0d answers (%0d in)",
                 beats_sent, sb.n_summary, sb.n_overflow, sb.n_answers, sb.n_in);
        $display("%0d queries had no polygon; %0d results matched, %0d failed",
                 sb.n_no_poly, sb.matched, sb.failures);
        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/ppi_pkg.sv
design/ppi_vram.sv
design/ppi_area.sv
design/ppi_edge.sv
design/polygon_point_inclusion.sv
tb/testbench.sv
